[rtl/median_filter_3x3_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the 3x3 median filter
// Shared shorthand for the concurrent checks on the filter's ports.
// ----------------------------------------------------------------------------
`ifndef MEDIAN_FILTER_3X3_DEFINES_SVH
`define MEDIAN_FILTER_3X3_DEFINES_SVH

// Checked on every rising edge of clk_i outside reset.
`define MF3_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising edge of clk_i, reset included.
`define MF3_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[rtl/mf3_pkg.sv]
// ----------------------------------------------------------------------------
// mf3_pkg
// Types, constants and compare-exchange helpers of the 3x3 median filter.
// ----------------------------------------------------------------------------
package mf3_pkg;

  localparam int WIN_TAPS  = 9;
  localparam int JOB_SLOTS = 4;

  localparam logic [12:0] WIDTH_RESET  = 13'd4096;
  localparam logic [15:0] HEIGHT_RESET = 16'd1024;

  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef logic [15:0] pix_t;
  typedef logic [WIN_TAPS-1:0][15:0] pix9_t;

  typedef struct packed {
    logic [11:0] col;
    logic [15:0] row;
    logic        last;
  } side_t;

  typedef struct packed {
    pix9_t vals;
    side_t side;
  } job_t;

  function automatic pix9_t cmp_swap(input pix9_t p, input logic [3:0] i, input logic [3:0] j);
    pix9_t r;
    r = p;
    if (p[i] > p[j]) begin
      r[i] = p[j];
      r[j] = p[i];
    end
    return r;
  endfunction

  // Sorts each group of three.
  function automatic pix9_t med_rows(input pix9_t p);
    pix9_t r;
    r = p;
    r = cmp_swap(r, 4'd1, 4'd2);
    r = cmp_swap(r, 4'd4, 4'd5);
    r = cmp_swap(r, 4'd7, 4'd8);
    r = cmp_swap(r, 4'd0, 4'd1);
    r = cmp_swap(r, 4'd3, 4'd4);
    r = cmp_swap(r, 4'd6, 4'd7);
    r = cmp_swap(r, 4'd1, 4'd2);
    r = cmp_swap(r, 4'd4, 4'd5);
    r = cmp_swap(r, 4'd7, 4'd8);
    return r;
  endfunction

  function automatic pix9_t med_mid(input pix9_t p);
    pix9_t r;
    r = p;
    r = cmp_swap(r, 4'd0, 4'd3);
    r = cmp_swap(r, 4'd5, 4'd8);
    r = cmp_swap(r, 4'd4, 4'd7);
    r = cmp_swap(r, 4'd3, 4'd6);
    r = cmp_swap(r, 4'd1, 4'd4);
    r = cmp_swap(r, 4'd2, 4'd5);
    r = cmp_swap(r, 4'd4, 4'd7);
    return r;
  endfunction

  function automatic pix_t med_final(input pix9_t p);
    pix9_t r;
    r = p;
    r = cmp_swap(r, 4'd4, 4'd2);
    r = cmp_swap(r, 4'd6, 4'd4);
    r = cmp_swap(r, 4'd4, 4'd2);
    return r[4];
  endfunction

endpackage

[rtl/mf3_ram.sv]
// ----------------------------------------------------------------------------
// mf3_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module mf3_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/mf3_window.sv]
// ----------------------------------------------------------------------------
// mf3_window
// Position tracking, row stores, 3x3 window and the issue of median jobs.
// ----------------------------------------------------------------------------
module mf3_window import mf3_pkg::*; #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [15:0] pixel_i,
  input  logic [16:0] width_i,
  input  logic [15:0] height_i,
  input  logic        en_i,
  output logic        job_valid_o,
  output job_t        job_o
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  logic          accept;
  logic [CW-1:0] col_q, col_d, c_in;
  logic [15:0]   row_q, row_d, r_in;
  logic          wrap, left1, left2, last_col, up1, up2, last_row;
  logic [JOB_SLOTS-1:0] mask_in;

  // Fetch stage: the transaction waits here for the row-store read.
  logic                 a_valid_q;
  logic [15:0]          a_pix_q;
  logic [CW-1:0]        a_col_q;
  logic [15:0]          a_row_q;
  logic [JOB_SLOTS-1:0] a_mask_q;
  logic                 a_left1_q, a_left2_q, a_up1_q, a_up2_q, a_byp_q;
  logic [31:0]          byp_q, ram_rdata, rd;
  logic [15:0]          older, prev;
  logic                 a_move;

  // Issue stage: hands out one window per cycle while en_i is high.
  logic                 e_valid_q;
  logic [JOB_SLOTS-1:0] e_mask_q, pick, rest;
  logic [CW-1:0]        e_col_q;
  logic [15:0]          e_row_q;
  logic                 e_left1_q, e_left2_q, e_up1_q, e_up2_q;
  logic                 done, emit, e_free;

  logic [15:0] cells_q [3][3];
  logic        job_valid_q;
  job_t        job_q, job_d;

  assign accept = valid_i && !stall_o;

  always_comb begin
    wrap     = (17'(col_q) >= width_i) || (row_q >= height_i);
    c_in     = wrap ? '0 : col_q;
    r_in     = wrap ? '0 : row_q;
    left1    = (c_in != '0);
    left2    = (17'(c_in) >= 17'd2);
    last_col = (17'(c_in) == (width_i - 17'd1));
    up1      = (r_in != '0);
    up2      = (r_in >= 16'd2);
    last_row = (r_in == (height_i - 16'd1));
    mask_in  = {last_row && last_col, last_row && left1, up1 && last_col, up1 && left1};
    col_d    = col_q;
    row_d    = row_q;
    if (accept) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : r_in + 16'd1;
      end else begin
        col_d = c_in + CW'(1);
        row_d = r_in;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  always_comb begin
    pick   = e_mask_q & (~e_mask_q + JOB_SLOTS'(1));
    rest   = e_mask_q & ~pick;
    done   = (rest == '0);
    emit   = e_valid_q && en_i;
    e_free = !e_valid_q || (emit && done);
    a_move = a_valid_q && e_free;
  end

  assign stall_o = a_valid_q && !e_free;

  // Older and previous row share one memory word: {older, previous}.
  mf3_ram #(
    .WIDTH (32),
    .DEPTH (MAX_WIDTH)
  ) u_rows (
    .clk_i   (clk_i),
    .we_i    (a_move),
    .waddr_i (a_col_q),
    .wdata_i ({prev, a_pix_q}),
    .re_i    (accept),
    .raddr_i (c_in),
    .rdata_o (ram_rdata)
  );

  // A read issued at the edge that writes the same column sees the new word.
  assign rd    = a_byp_q ? byp_q : ram_rdata;
  assign older = rd[31:16];
  assign prev  = rd[15:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (accept) begin
      a_valid_q <= 1'b1;
    end else if (a_move) begin
      a_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_pix_q   <= pixel_i;
      a_col_q   <= c_in;
      a_row_q   <= r_in;
      a_mask_q  <= mask_in;
      a_left1_q <= left1;
      a_left2_q <= left2;
      a_up1_q   <= up1;
      a_up2_q   <= up2;
      a_byp_q   <= a_move && (c_in == a_col_q);
    end
    if (a_move) begin
      byp_q <= {prev, a_pix_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          cells_q[i][j] <= '0;
        end
      end
    end else if (a_move) begin
      for (int i = 0; i < 3; i++) begin
        cells_q[i][0] <= cells_q[i][1];
        cells_q[i][1] <= cells_q[i][2];
      end
      cells_q[0][2] <= older;
      cells_q[1][2] <= prev;
      cells_q[2][2] <= a_pix_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q <= 1'b0;
      e_mask_q  <= '0;
    end else if (a_move) begin
      e_valid_q <= (a_mask_q != '0);
      e_mask_q  <= a_mask_q;
    end else if (emit) begin
      e_valid_q <= !done;
      e_mask_q  <= rest;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_move) begin
      e_col_q   <= a_col_q;
      e_row_q   <= a_row_q;
      e_left1_q <= a_left1_q;
      e_left2_q <= a_left2_q;
      e_up1_q   <= a_up1_q;
      e_up2_q   <= a_up2_q;
    end
  end

  // Slot bit 1 and 3 centre on the newest column, bits 2 and 3 on the newest row.
  // A neighbour outside the frame takes the centre value.
  always_comb begin
    logic        xsel, ysel, up_ok, left_ok, ok;
    logic [1:0]  ri, ci, rc, cc;
    logic [15:0] pad [4][4];
    logic [15:0] centre;
    xsel    = pick[1] | pick[3];
    ysel    = pick[2] | pick[3];
    up_ok   = ysel ? e_up1_q : e_up2_q;
    left_ok = xsel ? e_left1_q : e_left2_q;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        pad[i][j] = '0;
      end
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        pad[i][j] = cells_q[i][j];
      end
    end
    rc     = ysel ? 2'd2 : 2'd1;
    cc     = xsel ? 2'd2 : 2'd1;
    centre = pad[rc][cc];
    job_d  = '0;
    for (int a = 0; a < 3; a++) begin
      for (int b = 0; b < 3; b++) begin
        ri = 2'(a) + {1'b0, ysel};
        ci = 2'(b) + {1'b0, xsel};
        ok = !((a == 0) && !up_ok) && !((a == 2) && ysel) &&
             !((b == 0) && !left_ok) && !((b == 2) && xsel);
        job_d.vals[a*3+b] = ok ? pad[ri][ci] : centre;
      end
    end
    job_d.side.col  = xsel ? 12'(e_col_q) : 12'(e_col_q - CW'(1));
    job_d.side.row  = ysel ? e_row_q : e_row_q - 16'd1;
    job_d.side.last = done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
    end else if (en_i) begin
      job_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      job_q <= job_d;
    end
  end

  assign job_valid_o = job_valid_q;
  assign job_o       = job_q;

endmodule

[rtl/mf3_median9.sv]
// ----------------------------------------------------------------------------
// mf3_median9
// Three-stage median-of-nine compare-exchange network.
// ----------------------------------------------------------------------------
module mf3_median9 import mf3_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  valid_i,
  input  job_t  job_i,
  output logic  valid_o,
  output pix_t  median_o,
  output side_t side_o
);

  logic  s1_valid_q, s2_valid_q, s3_valid_q;
  pix9_t s1_vals_q, s2_vals_q;
  side_t s1_side_q, s2_side_q, s3_side_q;
  pix_t  s3_med_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else if (en_i) begin
      s1_valid_q <= valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_vals_q <= med_rows(job_i.vals);
      s1_side_q <= job_i.side;
      s2_vals_q <= med_mid(s1_vals_q);
      s2_side_q <= s1_side_q;
      s3_med_q  <= med_final(s2_vals_q);
      s3_side_q <= s2_side_q;
    end
  end

  assign valid_o  = s3_valid_q;
  assign median_o = s3_med_q;
  assign side_o   = s3_side_q;

endmodule

[rtl/median_filter_3x3.sv]
// ----------------------------------------------------------------------------
// median_filter_3x3
// Path: fetch stage, issue stage, job register, then the median network.
// Throughput: one pixel per cycle unless the output stalls; a pixel that
// completes n windows holds the issue stage until all are handed out and so
// stalls the input, as it hands one window a cycle to the single median network.
// Reset clears position, window and pipeline.
// ----------------------------------------------------------------------------
module median_filter_3x3 import mf3_pkg::*; #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] pixel_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] median_value_o,
  output logic [11:0] out_column_o,
  output logic [15:0] out_row_o,
  output logic        last_of_run_o,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam logic [16:0] MAXW = 17'(MAX_WIDTH);

  logic [12:0] width_q;
  logic [15:0] height_q;
  logic [16:0] width_eff;
  logic [15:0] height_eff;
  logic        en;
  logic        job_valid;
  job_t        job;
  side_t       side;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_IMAGE_WIDTH:  width_q  <= cfg_data_i[12:0];
        REG_IMAGE_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // A zero size acts as one; the width saturates at the row-store depth.
  always_comb begin
    if (width_q == '0) begin
      width_eff = 17'd1;
    end else if ({4'b0, width_q} > MAXW) begin
      width_eff = MAXW;
    end else begin
      width_eff = {4'b0, width_q};
    end
    height_eff = (height_q == '0) ? 16'd1 : height_q;
  end

  // The whole result pipeline advances unless a result waits on a stalled output.
  assign en = !(out_valid_o && out_stall_i);

  mf3_window #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (in_valid_i),
    .stall_o     (in_stall_o),
    .pixel_i     (pixel_value_i),
    .width_i     (width_eff),
    .height_i    (height_eff),
    .en_i        (en),
    .job_valid_o (job_valid),
    .job_o       (job)
  );

  mf3_median9 u_median (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (job_valid),
    .job_i    (job),
    .valid_o  (out_valid_o),
    .median_o (median_value_o),
    .side_o   (side)
  );

  assign out_column_o  = side.col;
  assign out_row_o     = side.row;
  assign last_of_run_o = side.last;

endmodule

[rtl/mf3_checker.sv]
// ----------------------------------------------------------------------------
// mf3_checker
// Port-level checks of the 3x3 median filter, bound to the top level.
// ----------------------------------------------------------------------------
`include "median_filter_3x3_defines.svh"

module mf3_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] median_value_o,
  input logic [15:0] out_row_o,
  input logic        last_of_run_o
);

  // A stalled result transaction keeps its payload.
  `MF3_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(median_value_o) && $stable(out_row_o), "stalled result changed")

  // Results of one run leave back to back once the output is taken.
  `MF3_ASSERT(a_run_cont, out_valid_o && !out_stall_i && !last_of_run_o |=> out_valid_o, "gap inside a run of results")

  // No centre row can reach the all-ones value.
  `MF3_ASSERT(a_row_range, out_valid_o |-> out_row_o != 16'hFFFF, "result row out of range")

  // Reset empties the pipeline and the fetch stage by the following edge.
  `MF3_ASSERT_ALWAYS(a_rst_clear, !rst_ni |=> !out_valid_o && !in_stall_o, "reset did not clear")

endmodule

bind median_filter_3x3 mf3_checker u_mf3_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .median_value_o (median_value_o),
  .out_row_o      (out_row_o),
  .last_of_run_o  (last_of_run_o)
);

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for median_filter_3x3
// Streams pixel frames of many shapes through the filter and checks every
// median, column, row and end-of-run flag against a predictor that keeps its
// own line buffers, window and position, with random gaps on both sides.
// ----------------------------------------------------------------------------
module tb;
  import mf3_pkg::*;

  localparam int MAX_W        = 4096;
  localparam int SETTLE       = 12;    // pipeline depth plus the longest burst
  localparam int LONG_HOLD    = 300;
  localparam int QUIET_LIMIT  = 4000;
  localparam int RANDOM_ITEMS = 110;
  localparam int WIDE_PIXELS  = 16;

  typedef enum int {PIX_ANY, PIX_RAILS, PIX_TIES, PIX_LOW} pix_mix_e;

  typedef struct packed {
    logic [15:0] median;
    logic [11:0] column;
    logic [15:0] row;
    logic        last;
  } median_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [15:0] pixel_value_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] median_value_o;
  logic [11:0] out_column_o;
  logic [15:0] out_row_o;
  logic        last_of_run_o;
  logic        cfg_we_i = 1'b0;
  logic        cfg_index_i = 1'b0;
  logic [15:0] cfg_data_i = '0;

  median_filter_3x3 #(.MAX_WIDTH(MAX_W)) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .pixel_value_i (pixel_value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .median_value_o(median_value_o),
    .out_column_o  (out_column_o),
    .out_row_o     (out_row_o),
    .last_of_run_o (last_of_run_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Predictor state.
  logic [15:0]   older_row [MAX_W];
  logic [15:0]   prev_row [MAX_W];
  logic [15:0]   cells [9];
  int            col_pos;
  int            row_pos;
  logic [12:0]   width_reg;
  logic [15:0]   height_reg;

  logic [15:0]   pending_pixels [$];
  median_res_t   expected_medians [$];

  int            send_gap;
  int            recv_gap;
  bit            send_idle_en;
  bit            recv_idle_en;
  logic          long_hold_go = 1'b0;
  bit            long_hold_done;
  int            hold_count;
  int            quiet_cycles;
  int            pixels_taken;
  int            medians_checked;
  int            mismatches;
  int            settings_count;

  function automatic int eff_width(input logic [12:0] v);
    if (v == 0) return 1;
    if (v > MAX_W) return MAX_W;
    return v;
  endfunction

  function automatic int eff_height(input logic [15:0] v);
    return (v == 0) ? 1 : v;
  endfunction

  // Fifth smallest: the value with at most four strictly below it and at
  // least five at or below it.
  function automatic logic [15:0] middle_of_nine(input logic [8:0][15:0] v);
    int below;
    int not_above;
    for (int i = 0; i < 9; i++) begin
      below = 0;
      not_above = 0;
      for (int j = 0; j < 9; j++) begin
        if (v[j] < v[i]) below++;
        if (v[j] <= v[i]) not_above++;
      end
      if (below <= 4 && not_above >= 5) return v[i];
    end
    return v[4];
  endfunction

  // Median around (x, y) while the newest window column is column c of row r.
  function automatic logic [15:0] window_middle(input int x, input int y, input int c,
                                                input int r, input int w, input int h);
    logic [8:0][15:0] v;
    logic [15:0] centre;
    int cx;
    int ry;
    int n;
    int nx;
    int ny;
    cx = 2 - (c - x);
    ry = 2 - (r - y);
    centre = cells[ry * 3 + cx];
    n = 0;
    for (int dy = -1; dy <= 1; dy++) begin
      for (int dx = -1; dx <= 1; dx++) begin
        nx = x + dx;
        ny = y + dy;
        v[n] = centre;
        if (nx >= 0 && nx < w && ny >= 0 && ny < h)
          v[n] = cells[(ry + dy) * 3 + cx + dx];
        n++;
      end
    end
    return middle_of_nine(v);
  endfunction

  task automatic filter_pixel(input logic [15:0] p);
    int w;
    int h;
    int c;
    int r;
    int xs [2];
    int ys [2];
    int nxs;
    int nys;
    int total;
    int k;
    median_res_t res;
    w = eff_width(width_reg);
    h = eff_height(height_reg);
    c = col_pos;
    r = row_pos;
    if (c >= w || r >= h) begin
      c = 0;
      r = 0;
    end
    for (int i = 0; i < 3; i++) begin
      cells[i * 3]     = cells[i * 3 + 1];
      cells[i * 3 + 1] = cells[i * 3 + 2];
    end
    cells[2] = older_row[c];
    cells[5] = prev_row[c];
    cells[8] = p;
    older_row[c] = prev_row[c];
    prev_row[c] = p;
    nxs = 0;
    nys = 0;
    if (r >= 1) begin ys[nys] = r - 1; nys++; end
    if (r == h - 1) begin ys[nys] = r; nys++; end
    if (c >= 1) begin xs[nxs] = c - 1; nxs++; end
    if (c == w - 1) begin xs[nxs] = c; nxs++; end
    total = nxs * nys;
    k = 0;
    for (int i = 0; i < nys; i++) begin
      for (int j = 0; j < nxs; j++) begin
        res.median = window_middle(xs[j], ys[i], c, r, w, h);
        res.column = 12'(xs[j]);
        res.row    = 16'(ys[i]);
        res.last   = (k == total - 1);
        expected_medians.push_back(res);
        k++;
      end
    end
    c++;
    if (c == w) begin
      c = 0;
      r++;
      if (r == h) r = 0;
    end
    col_pos = c;
    row_pos = r;
  endtask

  function automatic logic [15:0] pick_pixel(input pix_mix_e mix);
    case (mix)
      PIX_RAILS: return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
      PIX_TIES:  return 16'(16'h8000 + $urandom_range(0, 3));
      PIX_LOW:   return 16'($urandom_range(0, 15));
      default:   return 16'($urandom);
    endcase
  endfunction

  // Pixel source: each transaction is predicted as it is accepted.
  always @(posedge clk_i) begin : drive_pixels
    logic taken;
    logic offer;
    taken = in_valid_i && !in_stall_o;
    offer = 1'b0;
    if (rst_ni) begin
      if (taken) begin
        filter_pixel(pixel_value_i);
        pixels_taken++;
      end
      if (!in_valid_i || taken) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_pixels.size() != 0) begin
          if (send_idle_en && $urandom_range(0, 9) == 0) begin
            send_gap = $urandom_range(0, 18);
          end else begin
            offer = 1'b1;
          end
        end
        in_valid_i <= offer;
        if (offer) begin
          pixel_value_i <= pending_pixels.pop_front();
        end
      end
    end
  end

  always @(posedge clk_i) begin : drive_stall
    if (long_hold_go && !long_hold_done) begin
      hold_count++;
      if (hold_count == LONG_HOLD) long_hold_done = 1'b1;
      out_stall_i <= 1'b1;
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_stall_i <= 1'b1;
    end else if (recv_idle_en && $urandom_range(0, 9) == 0) begin
      recv_gap = $urandom_range(0, 18);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin : watch_results
    median_res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_medians.size() == 0) begin
        $error("median for column %0d row %0d arrived with none outstanding",
               out_column_o, out_row_o);
        mismatches++;
      end else begin
        want = expected_medians.pop_front();
        check_field("median_value", want.median, median_value_o);
        check_field("out_column", want.column, out_column_o);
        check_field("out_row", want.row, out_row_o);
        check_field("last_of_run", want.last, last_of_run_o);
        medians_checked++;
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("No transaction for %0d cycles, %0d medians outstanding",
               QUIET_LIMIT, expected_medians.size());
      $display("[median_filter_3x3] ERROR");
      $finish;
    end
  end

  task automatic write_reg(input cfg_reg_e idx, input logic [15:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_IMAGE_WIDTH) width_reg = data[12:0];
    else height_reg = data;
  endtask

  task automatic configure(input logic [15:0] w_data, input logic [15:0] h_data);
    write_reg(REG_IMAGE_WIDTH, w_data);
    write_reg(REG_IMAGE_HEIGHT, h_data);
    settings_count++;
  endtask

  // A width change part way through a frame would read line-buffer entries
  // that were never written, so such a change is turned into a restart.
  task automatic keep_stores_valid(inout int w, inout int h);
    if ((col_pos != 0 || row_pos != 0) && eff_width(13'(w)) != eff_width(width_reg) &&
        col_pos < eff_width(13'(w)) && row_pos < eff_height(16'(h))) begin
      if (row_pos > 0) h = row_pos;
      else w = col_pos;
    end
  endtask

  task automatic queue_frame(input int n, input pix_mix_e mix);
    @(negedge clk_i);
    repeat (n) pending_pixels.push_back(pick_pixel(mix));
  endtask

  task automatic drain();
    while (pending_pixels.size() != 0 || in_valid_i || expected_medians.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  initial begin
    int w_new;
    int h_new;
    int total;
    int n_pix;
    int frame_idx;
    int random_sent;
    bit cut_short;
    pix_mix_e mix;

    for (int i = 0; i < MAX_W; i++) begin
      older_row[i] = '0;
      prev_row[i] = '0;
    end
    for (int i = 0; i < 9; i++) cells[i] = '0;
    col_pos = 0;
    row_pos = 0;
    width_reg = WIDTH_RESET;
    height_reg = HEIGHT_RESET;
    send_idle_en = 1'b1;
    recv_idle_en = 1'b1;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset geometry: the first row of a tall frame gives nothing.
    @(negedge clk_i);
    pending_pixels.push_back(16'h0000);
    pending_pixels.push_back(16'hFFFF);
    pending_pixels.push_back(16'hA5A5);
    drain();

    // The position now lies outside a two-wide frame, so a new frame starts;
    // zero height behaves as one row.
    configure(16'd2, 16'd0);
    @(negedge clk_i);
    pending_pixels.push_back(16'hFFFF);
    pending_pixels.push_back(16'h0000);
    pending_pixels.push_back(16'h5555);
    pending_pixels.push_back(16'hAAAA);
    drain();

    // Zero width and height: a single-pixel frame, each median is the pixel.
    configure(16'd0, 16'd0);
    @(negedge clk_i);
    pending_pixels.push_back(16'h0000);
    pending_pixels.push_back(16'hFFFF);
    pending_pixels.push_back(16'h5555);
    drain();

    configure(16'd3, 16'd3);
    @(negedge clk_i);
    pending_pixels.push_back(16'h0000);
    pending_pixels.push_back(16'hFFFF);
    pending_pixels.push_back(16'h8000);
    pending_pixels.push_back(16'h0001);
    pending_pixels.push_back(16'h7FFF);
    pending_pixels.push_back(16'hFFFF);
    pending_pixels.push_back(16'h0000);
    pending_pixels.push_back(16'h5555);
    pending_pixels.push_back(16'hAAAA);
    drain();

    configure(16'd1, 16'd3);
    @(negedge clk_i);
    pending_pixels.push_back(16'h1234);
    pending_pixels.push_back(16'hFEDC);
    pending_pixels.push_back(16'h8001);
    drain();

    // An oversized width saturates; a short stretch of a one-row frame
    // exercises the bottom-edge padding at that width.
    configure(16'h1FFF, 16'd1);
    queue_frame(WIDE_PIXELS, PIX_ANY);
    drain();

    frame_idx = 0;
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      frame_idx++;
      w_new = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 24) : $urandom_range(1, 8);
      h_new = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
      cut_short = ($urandom_range(0, 5) == 0);
      case (frame_idx)
        1: begin
          w_new = $urandom_range(2, 5);
          h_new = 65535;
          cut_short = 1'b1;
        end
        2: begin
          w_new = MAX_W;
          h_new = 2;
          cut_short = 1'b1;
        end
        3: begin
          w_new = 0;
          h_new = $urandom_range(2, 5);
        end
        4: begin
          w_new = 8;
          h_new = 6;
          cut_short = 1'b0;
        end
        default: ;
      endcase
      keep_stores_valid(w_new, h_new);
      configure({3'($urandom_range(0, 7)), 13'(w_new)}, 16'(h_new));
      send_idle_en = ($urandom_range(0, 3) != 0);
      recv_idle_en = ($urandom_range(0, 3) != 0);
      // Output held off while pixels keep coming, so the input backs up.
      if (frame_idx == 4) long_hold_go <= 1'b1;
      total = eff_width(width_reg) * eff_height(height_reg);
      n_pix = total;
      if (cut_short && total > 1) n_pix = $urandom_range(1, (total - 1 < 40) ? total - 1 : 40);
      case ($urandom_range(0, 5))
        0:       mix = PIX_RAILS;
        1:       mix = PIX_TIES;
        2:       mix = PIX_LOW;
        default: mix = PIX_ANY;
      endcase
      queue_frame(n_pix, mix);
      random_sent += n_pix;
      drain();
    end

    // Closing frame at full rate on both sides.
    send_idle_en = 1'b0;
    recv_idle_en = 1'b0;
    w_new = 6;
    h_new = 5;
    keep_stores_valid(w_new, h_new);
    configure(16'(w_new), 16'(h_new));
    queue_frame(eff_width(width_reg) * eff_height(height_reg), PIX_ANY);
    drain();

    $display("Run covered %0d pixels over %0d frame geometries, widths 1 to %0d.",
             pixels_taken, settings_count, MAX_W);
    $display("%0d medians compared, %0d mismatches.", medians_checked, mismatches);
    if (mismatches == 0) begin
      $display("[median_filter_3x3] OK");
    end else begin
      $display("[median_filter_3x3] ERROR");
    end
    $finish;
  end

endmodule
